// ===== rtl/montgomery_euler_prp_test_80bit_unit_assert.svh =====
// assertion macros for the euler prp unit
// used by the sequencer and the top level
`ifndef MONTGOMERY_EULER_PRP_TEST_80BIT_UNIT_ASSERT_SVH
`define MONTGOMERY_EULER_PRP_TEST_80BIT_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MEP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define MEP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/mep_pkg.sv =====
// package for the euler prp unit: word types and fixed constants
// no dependencies
package mep_pkg;

  localparam int unsigned LoBits  = 64;
  localparam int unsigned HiBits  = 16;
  localparam int unsigned InBits  = LoBits + HiBits;
  localparam int unsigned NewtonRounds = 8;

  typedef struct packed {
    logic [HiBits-1:0] modulus_high;
    logic [LoBits-1:0] modulus_low;
  } in_word_t;

  typedef struct packed {
    logic is_probable_prime;
    logic out_of_range;
  } out_word_t;

  // multiplier operation codes
  typedef enum logic [1:0] {
    MUL_LOW  = 2'd0,
    MUL_FULL = 2'd1
  } mul_op_t;

  // multiplier control bundle from sequencer
  typedef struct packed {
    logic go;
  } mul_ctl_t;

endpackage

// ===== rtl/mep_mul.sv =====
// shared iterative multiplier: 32x32 partial products, one per cycle
// depends on mep_pkg
module mep_mul
  import mep_pkg::*;
#(
  parameter int unsigned W = 80
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mul_ctl_t       ctl,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);
  localparam int unsigned D  = (W + 31) / 32;
  localparam int unsigned DW = D * 32;
  localparam int unsigned IW = (D > 1) ? $clog2(D) : 1;

  logic [DW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [2*DW-1:0] acc_r, acc_nxt;
  logic [IW-1:0]   ia_r, ia_nxt, ib_r, ib_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0]     pp;

  // current digit pair
  assign pp = 64'(a_r[ia_r*32 +: 32]) * 64'(b_r[ib_r*32 +: 32]);

  // one partial product per cycle, inner digit of b, outer digit of a
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; ia_nxt = ia_r; ib_nxt = ib_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (ctl.go) begin
      a_nxt = DW'(a); b_nxt = DW'(b); acc_nxt = '0; ia_nxt = '0; ib_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + ((2*DW)'(pp) << ((ia_r + ib_r) * 32));
      if (ib_r == IW'(D - 1)) begin
        ib_nxt = '0;
        if (ia_r == IW'(D - 1)) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end else begin
          ia_nxt = ia_r + 1'b1;
        end
      end else begin
        ib_nxt = ib_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; ia_r <= '0; ib_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; ia_r <= ia_nxt; ib_r <= ib_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r[2*W-1:0];
endmodule

// ===== rtl/mep_seq.sv =====
// sequencer: newton inverse, montgomery one, square-and-double ladder
// depends on mep_pkg, mep_mul, assertion macros
`include "montgomery_euler_prp_test_80bit_unit_assert.svh"
module mep_seq
  import mep_pkg::*;
#(
  parameter int unsigned W = 80
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      strobe,
  output out_word_t out_word
);
  localparam int unsigned BW = $clog2(W);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_NA    = 11'b00000000010,
    S_NB    = 11'b00000000100,
    S_ONE   = 11'b00000001000,
    S_EXP   = 11'b00000010000,
    S_SQ    = 11'b00000100000,
    S_SM    = 11'b00001000000,
    S_SU    = 11'b00010000000,
    S_FIN   = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [W-1:0] p_r, p_nxt, q_r, q_nxt, one_r, one_nxt, r_r, r_nxt;
  logic [W-1:0] t_r, t_nxt;          // high half of a*a
  logic [W-1:0] ma, mb;
  logic [W-1:0] p_in;
  logic [2*W-1:0] prod;
  logic [3:0] rnd_r, rnd_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic mdone;
  mul_ctl_t mctl;
  logic strobe_r, strobe_nxt;
  out_word_t res_r, res_nxt;
  logic [W-1:0] e;
  logic [W:0] r_dbl, dbl_one;
  logic [W-1:0] th, uh, diff;

  mep_mul #(.W(W)) u_mul (.clk(clk), .rst_n(rst_n), .ctl(mctl), .a(ma), .b(mb),
                          .done(mdone), .prod(prod));

  assign p_in = W'({in_word.modulus_high, in_word.modulus_low});
  assign e = p_r >> 1;
  assign r_dbl   = {r_r, 1'b0};
  assign dbl_one = {one_r, 1'b0};
  assign th = t_r;
  assign uh = prod[2*W-1:W];
  assign diff = th - uh;

  // operands for the product launched from each state
  always_comb begin
    ma = p_r; mb = q_r;
    case (state_r)
      S_IDLE:  begin ma = p_in;          mb = W'(2) - p_in; end
      S_NA:    begin ma = q_r;           mb = W'(2) - prod[W-1:0]; end
      S_NB:    begin ma = p_r;           mb = prod[W-1:0]; end
      S_NEXT:  begin ma = r_r;           mb = r_r; end
      S_SQ:    begin ma = prod[W-1:0];   mb = q_r; end
      S_SM:    begin ma = prod[W-1:0];   mb = p_r; end
      default: begin ma = p_r;           mb = q_r; end
    endcase
  end

  // main sequencer
  always_comb begin
    logic odd, above, below;
    state_nxt = state_r; p_nxt = p_r; q_nxt = q_r; one_nxt = one_r; r_nxt = r_r;
    t_nxt = t_r; rnd_nxt = rnd_r; bit_nxt = bit_r; mctl.go = 1'b0;
    strobe_nxt = 1'b0; res_nxt = res_r;
    odd = in_word.modulus_low[0];
    above = (in_word.modulus_high != '0) || (in_word.modulus_low > {1'b1, 63'd0});
    below = !in_word.modulus_high[HiBits-1];
    case (state_r)
      S_IDLE: if (start) begin
        p_nxt = p_in;
        if (!(odd && above && below)) begin
          res_nxt = '{is_probable_prime: 1'b0, out_of_range: 1'b1};
          strobe_nxt = 1'b1;
        end else begin
          q_nxt = W'(2) - p_in;
          rnd_nxt = '0;
          mctl.go = 1'b1;
          state_nxt = S_NA;
        end
      end
      S_NA: if (mdone) begin
        mctl.go = 1'b1; state_nxt = S_NB;
      end
      S_NB: if (mdone) begin
        if (prod[W-1:0] == q_r || rnd_r == 4'(NewtonRounds - 1)) begin
          q_nxt = prod[W-1:0];
          one_nxt = W'(1); bit_nxt = '0; state_nxt = S_ONE;
        end else begin
          q_nxt = prod[W-1:0]; rnd_nxt = rnd_r + 1'b1;
          mctl.go = 1'b1; state_nxt = S_NA;
        end
      end
      S_ONE: begin
        one_nxt = (dbl_one >= {1'b0, p_r}) ? W'(dbl_one - {1'b0, p_r}) : dbl_one[W-1:0];
        if (bit_r == BW'(W - 1)) begin
          bit_nxt = BW'(W - 1); state_nxt = S_EXP;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      // find the top set bit of e, one bit a cycle
      S_EXP: begin
        if (e[bit_r] || bit_r == '0) begin
          r_nxt = one_r; state_nxt = S_FIN;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      // doubling seed then fall into the loop
      S_FIN: begin
        r_nxt = (r_dbl >= {1'b0, p_r}) ? W'(r_dbl - {1'b0, p_r}) : r_dbl[W-1:0];
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (bit_r == '0) begin
          res_nxt = '{is_probable_prime: (r_r == one_r) || (r_r == p_r - one_r),
                      out_of_range: 1'b0};
          strobe_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          bit_nxt = bit_r - 1'b1; mctl.go = 1'b1; state_nxt = S_SQ;
        end
      end
      S_SQ: if (mdone) begin
        t_nxt = prod[2*W-1:W]; mctl.go = 1'b1; state_nxt = S_SM;
      end
      S_SM: if (mdone) begin
        mctl.go = 1'b1; state_nxt = S_SU;
      end
      S_SU: if (mdone) begin
        r_nxt = (th >= uh) ? diff : diff + p_r;
        state_nxt = S_OUT;
      end
      // optional double on a set exponent bit
      S_OUT: begin
        if (e[bit_r])
          r_nxt = (r_dbl >= {1'b0, p_r}) ? W'(r_dbl - {1'b0, p_r}) : r_dbl[W-1:0];
        state_nxt = S_NEXT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt; strobe_r <= strobe_nxt;
    end
    p_r <= p_nxt; q_r <= q_nxt; one_r <= one_nxt; r_r <= r_nxt; t_r <= t_nxt;
    rnd_r <= rnd_nxt; bit_r <= bit_nxt; res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign strobe = strobe_r;
  assign out_word = res_r;

  `MEP_ASSERT_NXT(a_strobe_ends_job, clk, rst_n, strobe_r && !start, !strobe_r)
  `MEP_ASSERT_IMP(a_no_strobe_busy, clk, rst_n, strobe_r, state_r == S_IDLE)
  `MEP_ASSERT_IMP(a_bad_flag_zero, clk, rst_n, strobe_r && res_r.out_of_range,
                  !res_r.is_probable_prime)
endmodule

// ===== rtl/montgomery_euler_prp_test_80bit_unit.sv =====
// top level of the base-2 euler prp unit
// depends on mep_pkg, mep_seq, mep_mul
//
// Usage: drive in_word and raise start while busy is low; the word is taken
// at that edge and busy rises for a valid modulus. A word that is even or
// outside (2^63, 2^79) answers in the next cycle with out_of_range set. A
// valid modulus runs the newton inverse (up to 16 products), doubles W times
// for the montgomery one, searches down from bit W-1 for the top set bit of
// e, then runs 3 products plus the S_OUT and S_NEXT steps for each exponent
// bit. Every product runs on the one shared 32x32 multiplier as 9 partial
// products after a load at 80 bits, so the ladder dominates the run time.
// The result appears on out_word with out_strobe high for exactly one cycle;
// the receiver cannot stall it. Synchronous reset returns the unit to idle
// and drops any word in flight.
`include "montgomery_euler_prp_test_80bit_unit_assert.svh"
module montgomery_euler_prp_test_80bit_unit
  import mep_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = 80
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);
  localparam int unsigned MontBits =
    (MODULUS_BITS < 80) ? 80 : ((MODULUS_BITS > 128) ? 128 : MODULUS_BITS);

  mep_seq #(.W(MontBits)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .strobe(out_strobe), .out_word(out_word)
  );

  `MEP_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy && !out_strobe,
                  busy || out_strobe)
endmodule
